// ===== rtl/core/bsa_pkg.sv =====
package bsa_pkg;

    localparam int SLOT_W      = 13;
    localparam int STATUS_W    = 2;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int SUM_BITS    = 32;
    localparam int SUM_POS_W   = 5;
    localparam int FFZ_W       = 64;
    localparam int FFZ_POS_W   = 6;
    localparam int DIV_SHIFT   = SLOT_W + 7;
    localparam int DIV_MUL_W   = 18;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ASUM,
        S_AWORD,
        S_FA,
        S_FB,
        S_FRD,
        S_FCHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 found;
        logic [FFZ_POS_W-1:0] pos;
    } t_ffz;

    function automatic t_ffz find_first_zero(input logic [FFZ_W-1:0] v);
        t_ffz r;
        r.found = 1'b0;
        r.pos   = '0;
        for (int i = FFZ_W - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r.found = 1'b1;
                r.pos   = FFZ_POS_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/bsa_ram.sv =====
module bsa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/bsa_slot_split.sv =====
module bsa_slot_split #(
    parameter int WORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic [bsa_pkg::SLOT_W-1:0]      i_slot,
    output logic [bsa_pkg::SLOT_W-1:0]      o_word,
    output logic [$clog2(WORD_BITS)-1:0]    o_bit
);

    import bsa_pkg::*;

    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int PROD_W  = SLOT_W + DIV_MUL_W;
    localparam int DIV_MUL = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

    logic [PROD_W-1:0] w_prod;
    logic [SLOT_W-1:0] w_back;
    logic [SLOT_W-1:0] w_rem;
    logic [SLOT_W-1:0] r_q;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_word;
    logic [BIT_W-1:0]  r_bit;

    // quotient by reciprocal, exact for every 13-bit slot
    assign w_prod = PROD_W'(i_slot) * PROD_W'(DIV_MUL);
    assign w_back = SLOT_W'(r_q * SLOT_W'(WORD_BITS));
    assign w_rem  = r_slot - w_back;

    always_ff @(posedge i_clk) begin
        r_q    <= SLOT_W'(w_prod >> DIV_SHIFT);
        r_slot <= i_slot;
        r_word <= r_q;
        r_bit  <= BIT_W'(w_rem);
    end

    assign o_word = r_word;
    assign o_bit  = r_bit;

endmodule

// ===== rtl/core/bitmap_slot_allocator_core.sv =====
// First-fit slot allocator over NUM_SLOTS slots, one used bit per slot, kept in a word
// memory of WORD_BITS-bit words beside a summary memory holding one full flag per word
// (32 flags per entry) and a hint register naming the lowest summary entry that may still
// hold a free word. After reset a clearing pass writes zero to every word and summary entry,
// one a cycle, while no request is taken. An allocate reads the summary entry at the hint,
// stepping over each fully used entry, then reads the word and sets its bit; a free first
// splits the slot number into word and bit, and a free of a slot past the pool is answered
// as not used without a read. Any other request is a read of the memories, a check and,
// where a bit changes, a write back. A result sits in the output register, so the next
// request is taken while it waits; a request finishing while the previous result is still
// untaken holds until that beat goes.
module bitmap_slot_allocator_core #(
    parameter int NUM_SLOTS = 8192,
    parameter int WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bsa_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // opcode, slot_index
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bsa_pkg::TDATA_OUT_W-1:0]   m_axis_tdata    // status, granted_slot
);

    import bsa_pkg::*;

    localparam int NUM_WORDS     = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int NUM_SUMS      = (NUM_WORDS + SUM_BITS - 1) / SUM_BITS;
    localparam int SIDX_W        = (NUM_SUMS > 1) ? $clog2(NUM_SUMS) : 1;
    localparam int LAST_BITS     = NUM_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
    localparam int SUM_LAST_BITS = NUM_WORDS - (NUM_SUMS - 1) * SUM_BITS;

    localparam logic [FFZ_W-1:0] PAD_WORD      = ~((FFZ_W'(1) << WORD_BITS) - FFZ_W'(1));
    localparam logic [FFZ_W-1:0] PAD_WORD_LAST = ~((FFZ_W'(1) << LAST_BITS) - FFZ_W'(1));
    localparam logic [FFZ_W-1:0] PAD_SUM       = ~((FFZ_W'(1) << SUM_BITS) - FFZ_W'(1));
    localparam logic [FFZ_W-1:0] PAD_SUM_LAST  = ~((FFZ_W'(1) << SUM_LAST_BITS) - FFZ_W'(1));
    localparam logic [WIDX_W-1:0] LAST_WIDX    = WIDX_W'(NUM_WORDS - 1);
    localparam logic [SIDX_W-1:0] LAST_SIDX    = SIDX_W'(NUM_SUMS - 1);

    t_state                  r_state, n_state;
    logic [WIDX_W-1:0]       r_clr, n_clr;
    logic [SIDX_W-1:0]       r_hint, n_hint;
    logic [WIDX_W-1:0]       r_widx, n_widx;
    logic [SUM_BITS-1:0]     r_sumd, n_sumd;
    t_status                 r_status, n_status;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic                    r_out_valid, n_out_valid;
    logic [TDATA_OUT_W-1:0]  r_out_data, n_out_data;

    logic                    w_word_rd_en, w_word_wr_en;
    logic [WIDX_W-1:0]       w_word_rd_addr, w_word_wr_addr;
    logic [WORD_BITS-1:0]    w_word_rd, w_word_wr_data;
    logic                    w_sum_rd_en, w_sum_wr_en;
    logic [SIDX_W-1:0]       w_sum_rd_addr, w_sum_wr_addr;
    logic [SUM_BITS-1:0]     w_sum_rd, w_sum_wr_data;

    logic [SLOT_W-1:0]       w_split_word;
    logic [BIT_W-1:0]        w_split_bit;
    logic [WIDX_W-1:0]       w_free_widx;
    logic [SIDX_W-1:0]       w_free_sidx;
    logic [SUM_POS_W-1:0]    w_free_spos;
    logic [WORD_BITS-1:0]    w_free_bit;

    logic [FFZ_W-1:0]        w_word_mask, w_sum_mask;
    t_ffz                    w_word_ffz, w_sum_ffz;
    logic [WIDX_W-1:0]       w_alloc_widx;
    logic [WORD_BITS-1:0]    w_alloc_bit;
    logic                    w_word_now_full;
    logic [SLOT_W-1:0]       w_alloc_slot;
    logic                    w_in_beat;
    t_opcode                 w_in_op;
    logic [SLOT_W-1:0]       w_in_slot;

    bsa_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WIDX_W)
    ) u_word_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_word_rd_en),
        .i_rd_addr (w_word_rd_addr),
        .o_rd_data (w_word_rd),
        .i_wr_en   (w_word_wr_en),
        .i_wr_addr (w_word_wr_addr),
        .i_wr_data (w_word_wr_data)
    );

    bsa_ram #(
        .DEPTH (NUM_SUMS),
        .WIDTH (SUM_BITS),
        .AW    (SIDX_W)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_sum_rd_en),
        .i_rd_addr (w_sum_rd_addr),
        .o_rd_data (w_sum_rd),
        .i_wr_en   (w_sum_wr_en),
        .i_wr_addr (w_sum_wr_addr),
        .i_wr_data (w_sum_wr_data)
    );

    bsa_slot_split #(
        .WORD_BITS (WORD_BITS)
    ) u_split (
        .i_clk  (i_clk),
        .i_slot (r_slot),
        .o_word (w_split_word),
        .o_bit  (w_split_bit)
    );

    assign w_in_beat = s_axis_tvalid && s_axis_tready;
    assign w_in_op   = t_opcode'(s_axis_tdata[0]);
    assign w_in_slot = s_axis_tdata[SLOT_W:1];

    assign w_free_widx = WIDX_W'(w_split_word);
    assign w_free_sidx = SIDX_W'(w_free_widx >> SUM_POS_W);
    assign w_free_spos = SUM_POS_W'(w_free_widx);
    assign w_free_bit  = WORD_BITS'(1) << w_split_bit;

    // slots past the pool and words past the last count as used
    assign w_word_mask = FFZ_W'(w_word_rd) | PAD_WORD
                       | ((r_widx == LAST_WIDX) ? PAD_WORD_LAST : '0);
    assign w_sum_mask  = FFZ_W'(w_sum_rd) | PAD_SUM
                       | ((r_hint == LAST_SIDX) ? PAD_SUM_LAST : '0);
    assign w_word_ffz  = find_first_zero(w_word_mask);
    assign w_sum_ffz   = find_first_zero(w_sum_mask);

    assign w_alloc_widx    = WIDX_W'(32'(r_hint) * SUM_BITS + 32'(w_sum_ffz.pos));
    assign w_alloc_bit     = WORD_BITS'(1) << w_word_ffz.pos;
    assign w_word_now_full = &(w_word_mask | (FFZ_W'(1) << w_word_ffz.pos));
    assign w_alloc_slot    = SLOT_W'(32'(r_widx) * WORD_BITS + 32'(w_word_ffz.pos));

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx     <= n_widx;
        r_sumd     <= n_sumd;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        n_hint         = r_hint;
        n_widx         = r_widx;
        n_sumd         = r_sumd;
        n_status       = r_status;
        n_slot         = r_slot;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_out_data     = r_out_data;
        w_word_rd_en   = 1'b0;
        w_word_rd_addr = r_widx;
        w_word_wr_en   = 1'b0;
        w_word_wr_addr = r_widx;
        w_word_wr_data = '0;
        w_sum_rd_en    = 1'b0;
        w_sum_rd_addr  = r_hint;
        w_sum_wr_en    = 1'b0;
        w_sum_wr_addr  = r_hint;
        w_sum_wr_data  = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_word_wr_en   = 1'b1;
                w_word_wr_addr = r_clr;
                w_sum_wr_en    = (32'(r_clr) < NUM_SUMS);
                w_sum_wr_addr  = SIDX_W'(r_clr);
                if (r_clr == LAST_WIDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_slot = w_in_slot;
                    if (w_in_op == OP_ALLOC) begin
                        w_sum_rd_en = 1'b1;
                        n_state     = S_ASUM;
                    end else if (32'(w_in_slot) >= NUM_SLOTS) begin
                        n_status = ST_NOT_USED;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_FA;
                    end
                end
            end
            S_ASUM: begin
                if (w_sum_ffz.found) begin
                    n_widx         = w_alloc_widx;
                    n_sumd         = w_sum_rd;
                    w_word_rd_en   = 1'b1;
                    w_word_rd_addr = w_alloc_widx;
                    n_state        = S_AWORD;
                end else if (r_hint == LAST_SIDX) begin
                    n_status = ST_FULL;
                    n_state  = S_OUT;
                end else begin
                    n_hint        = r_hint + 1'b1;
                    w_sum_rd_en   = 1'b1;
                    w_sum_rd_addr = r_hint + 1'b1;
                end
            end
            S_AWORD: begin
                w_word_wr_en   = 1'b1;
                w_word_wr_data = w_word_rd | w_alloc_bit;
                if (w_word_now_full) begin
                    w_sum_wr_en   = 1'b1;
                    w_sum_wr_data = r_sumd | (SUM_BITS'(1) << SUM_POS_W'(r_widx));
                end
                n_status = ST_OK;
                n_slot   = w_alloc_slot;
                n_state  = S_OUT;
            end
            S_FA: begin
                n_state = S_FB;
            end
            S_FB: begin
                n_state = S_FRD;
            end
            S_FRD: begin
                w_word_rd_en   = 1'b1;
                w_word_rd_addr = w_free_widx;
                w_sum_rd_en    = 1'b1;
                w_sum_rd_addr  = w_free_sidx;
                n_state        = S_FCHK;
            end
            S_FCHK: begin
                if (|(w_word_rd & w_free_bit)) begin
                    w_word_wr_en   = 1'b1;
                    w_word_wr_addr = w_free_widx;
                    w_word_wr_data = w_word_rd & ~w_free_bit;
                    w_sum_wr_en    = 1'b1;
                    w_sum_wr_addr  = w_free_sidx;
                    w_sum_wr_data  = w_sum_rd & ~(SUM_BITS'(1) << w_free_spos);
                    if (w_free_sidx < r_hint) begin
                        n_hint = w_free_sidx;
                    end
                    n_status = ST_OK;
                end else begin
                    n_status = ST_NOT_USED;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = TDATA_OUT_W'({r_slot, r_status});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // summary said the word has room, so the word must show a free slot
    a_summary_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AWORD) |-> w_word_ffz.found)
        else $error("summary flags a free word that has no free slot");

    a_grant_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AWORD) |-> (32'(r_widx) * WORD_BITS + 32'(w_word_ffz.pos) < NUM_SLOTS))
        else $error("granted slot lies past the pool");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result beat raised outside the output step");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state != S_IDLE) && (r_state != S_CLEAR))
        else $error("request beat taken without starting work");

endmodule
